[rtl/hscl_pkg.sv]
`default_nettype none

package hscl_pkg;

    // Table geometry and key/serial sizes
    localparam int IDX_BITS    = 7;
    localparam int SLOTS       = 1 << IDX_BITS;
    localparam int SLOT_W      = IDX_BITS;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int BCNT_W      = 3;
    localparam int SERIAL_BITS = 32;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        CMD_BIND   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_RESET  = 2'd3
    } t_cmd;

    // Datapath operations, one per microword
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_HASH,
        OP_HOME,
        OP_ADV,
        OP_CLAIM,
        OP_HIT,
        OP_BIND,
        OP_FULL,
        OP_INVAL,
        OP_RESET,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_INVAL,
        C_RESET,
        C_HASH_MORE,
        C_EMPTY,
        C_MATCH,
        C_PROBE_LAST,
        C_NOT_BIND,
        C_OUT_BUSY
    } t_cond;

    localparam int UPC_W = 5;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [UPC_W-1:0]  tgt;
    } t_uword;

    // Status from the datapath for jump decisions
    typedef struct packed {
        logic  in_fire;
        t_cmd  cmd;
        logic  hash_last;
        logic  empty;
        logic  match;
        logic  probe_last;
        logic  out_busy;
    } t_stat;

    // Program addresses
    localparam logic [UPC_W-1:0] A_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] A_DISP  = 5'd1;
    localparam logic [UPC_W-1:0] A_DISP2 = 5'd2;
    localparam logic [UPC_W-1:0] A_HASH  = 5'd3;
    localparam logic [UPC_W-1:0] A_HOME  = 5'd4;
    localparam logic [UPC_W-1:0] A_READ  = 5'd5;
    localparam logic [UPC_W-1:0] A_TST_E = 5'd6;
    localparam logic [UPC_W-1:0] A_TST_M = 5'd7;
    localparam logic [UPC_W-1:0] A_ADV   = 5'd8;
    localparam logic [UPC_W-1:0] A_LOOP  = 5'd9;
    localparam logic [UPC_W-1:0] A_CLAIM = 5'd10;
    localparam logic [UPC_W-1:0] A_HIT   = 5'd11;
    localparam logic [UPC_W-1:0] A_BCHK  = 5'd12;
    localparam logic [UPC_W-1:0] A_BIND  = 5'd13;
    localparam logic [UPC_W-1:0] A_FULL  = 5'd14;
    localparam logic [UPC_W-1:0] A_INVAL = 5'd15;
    localparam logic [UPC_W-1:0] A_RESET = 5'd16;
    localparam logic [UPC_W-1:0] A_EMIT  = 5'd17;
    localparam logic [UPC_W-1:0] A_DONE  = 5'd18;

    // Control store: a jump is taken when its condition holds, else fall through
    function automatic t_uword uc_rom(input logic [UPC_W-1:0] a);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, tgt: A_IDLE};
        unique case (a)
            A_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_IN,      tgt: A_IDLE};
            A_DISP:  w = '{op: OP_CLEAR, cond: C_INVAL,      tgt: A_INVAL};
            A_DISP2: w = '{op: OP_NOP,   cond: C_RESET,      tgt: A_RESET};
            A_HASH:  w = '{op: OP_HASH,  cond: C_HASH_MORE,  tgt: A_HASH};
            A_HOME:  w = '{op: OP_HOME,  cond: C_NEVER,      tgt: A_IDLE};
            A_READ:  w = '{op: OP_NOP,   cond: C_NEVER,      tgt: A_IDLE};
            A_TST_E: w = '{op: OP_NOP,   cond: C_EMPTY,      tgt: A_CLAIM};
            A_TST_M: w = '{op: OP_NOP,   cond: C_MATCH,      tgt: A_HIT};
            A_ADV:   w = '{op: OP_ADV,   cond: C_PROBE_LAST, tgt: A_FULL};
            A_LOOP:  w = '{op: OP_NOP,   cond: C_ALWAYS,     tgt: A_READ};
            A_CLAIM: w = '{op: OP_CLAIM, cond: C_ALWAYS,     tgt: A_BCHK};
            A_HIT:   w = '{op: OP_HIT,   cond: C_NEVER,      tgt: A_IDLE};
            A_BCHK:  w = '{op: OP_NOP,   cond: C_NOT_BIND,   tgt: A_EMIT};
            A_BIND:  w = '{op: OP_BIND,  cond: C_ALWAYS,     tgt: A_EMIT};
            A_FULL:  w = '{op: OP_FULL,  cond: C_ALWAYS,     tgt: A_EMIT};
            A_INVAL: w = '{op: OP_INVAL, cond: C_ALWAYS,     tgt: A_EMIT};
            A_RESET: w = '{op: OP_RESET, cond: C_ALWAYS,     tgt: A_EMIT};
            A_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,   tgt: A_EMIT};
            A_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,     tgt: A_IDLE};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,     tgt: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/hscl_useq.sv]
`default_nettype none

module hscl_useq
    import hscl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_stat  i_stat,
    output t_op         o_op
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w;
    logic             take;

    assign w    = uc_rom(r_upc);
    assign o_op = w.op;

    always_comb begin
        unique case (w.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_IN:      take = !i_stat.in_fire;
            C_INVAL:      take = (i_stat.cmd == CMD_INVAL);
            C_RESET:      take = (i_stat.cmd == CMD_RESET);
            C_HASH_MORE:  take = !i_stat.hash_last;
            C_EMPTY:      take = i_stat.empty;
            C_MATCH:      take = i_stat.match;
            C_PROBE_LAST: take = i_stat.probe_last;
            C_NOT_BIND:   take = (i_stat.cmd != CMD_BIND);
            C_OUT_BUSY:   take = i_stat.out_busy;
            default:      take = 1'b1;
        endcase
        n_upc = take ? w.tgt : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

[rtl/hscl_dpath.sv]
`default_nettype none

module hscl_dpath
    import hscl_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_op           i_op,
    output t_stat              o_stat,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [127:0]  i_s_axis_tdata,
    input  wire logic [1:0]    i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata
);

    // Captured item
    t_cmd                    r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic [SERIAL_BITS-1:0]  r_ms;
    logic [SERIAL_BITS-1:0]  r_us;

    logic [31:0]             r_hash;
    logic [31:0]             hx;
    logic [BCNT_W-1:0]       r_bcnt;
    logic [SLOT_W-1:0]       r_idx;
    logic [SLOT_W-1:0]       r_probe;

    logic [SLOTS-1:0]        r_valid;
    logic [SLOTS-1:0]        r_live;
    logic                    r_bound_valid;
    logic [SLOT_W-1:0]       r_bound_slot;

    logic r_hit, r_ins, r_full, r_sw, r_mu, r_uu;

    logic                    r_m_valid;
    logic [15:0]             r_m_data;

    // Slot store, registered read at the current probe slot
    logic [KEY_W-1:0]        key_mem [SLOTS];
    logic [SERIAL_BITS-1:0]  ms_mem  [SLOTS];
    logic [SERIAL_BITS-1:0]  us_mem  [SLOTS];
    logic [KEY_W-1:0]        r_key_q;
    logic [SERIAL_BITS-1:0]  r_ms_q;
    logic [SERIAL_BITS-1:0]  r_us_q;
    logic [SERIAL_BITS-1:0]  ms_old;
    logic [SERIAL_BITS-1:0]  us_old;

    logic in_fire;
    logic out_busy;

    assign o_s_axis_tready = (i_op == OP_LOAD);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_busy        = r_m_valid && !i_m_axis_tready;

    assign hx     = r_hash ^ {24'h0, r_key[{r_bcnt, 3'b000} +: 8]};
    // Serials of a slot not refreshed since claim or invalidate read as zero
    assign ms_old = r_live[r_idx] ? r_ms_q : '0;
    assign us_old = r_live[r_idx] ? r_us_q : '0;

    assign o_stat.in_fire    = in_fire;
    assign o_stat.cmd        = r_cmd;
    assign o_stat.hash_last  = (r_bcnt == BCNT_W'(KEY_BYTES - 1));
    assign o_stat.empty      = !r_valid[r_idx];
    assign o_stat.match      = (r_key_q == r_key);
    assign o_stat.probe_last = (r_probe == SLOT_W'(SLOTS - 1));
    assign o_stat.out_busy   = out_busy;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (i_op == OP_CLAIM) begin
            key_mem[r_idx] <= r_key;
        end
        if (i_op == OP_BIND) begin
            ms_mem[r_idx] <= r_ms;
            us_mem[r_idx] <= r_us;
        end
        r_key_q <= key_mem[r_idx];
        r_ms_q  <= ms_mem[r_idx];
        r_us_q  <= us_mem[r_idx];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_live        <= '0;
            r_bound_valid <= 1'b0;
            r_bound_slot  <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            // Load a new result when the output register frees up, else drop
            // the one taken downstream
            if (i_op == OP_EMIT && !out_busy) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (i_op)
                OP_CLAIM: begin
                    r_valid[r_idx] <= 1'b1;
                    r_live[r_idx]  <= 1'b0;
                end
                OP_BIND: begin
                    r_live[r_idx]  <= 1'b1;
                    r_bound_valid  <= 1'b1;
                    r_bound_slot   <= r_idx;
                end
                OP_INVAL: begin
                    r_live        <= '0;
                    r_bound_valid <= 1'b0;
                    r_bound_slot  <= '0;
                end
                OP_RESET: begin
                    r_valid       <= '0;
                    r_bound_valid <= 1'b0;
                    r_bound_slot  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (in_fire) begin
                    r_cmd  <= t_cmd'(i_s_axis_tuser);
                    r_key  <= i_s_axis_tdata[KEY_W-1:0];
                    r_ms   <= i_s_axis_tdata[64 +: SERIAL_BITS];
                    r_us   <= i_s_axis_tdata[96 +: SERIAL_BITS];
                    r_hash <= FNV_BASIS;
                    r_bcnt <= '0;
                end
            end
            OP_CLEAR: begin
                r_hit  <= 1'b0;
                r_ins  <= 1'b0;
                r_full <= 1'b0;
                r_sw   <= 1'b0;
                r_mu   <= 1'b0;
                r_uu   <= 1'b0;
            end
            OP_HASH: begin
                r_hash <= 32'(hx * FNV_PRIME);
                r_bcnt <= r_bcnt + 1'b1;
            end
            OP_HOME: begin
                r_idx   <= r_hash[SLOT_W-1:0];
                r_probe <= '0;
            end
            OP_ADV: begin
                r_idx   <= r_idx + 1'b1;
                r_probe <= r_probe + 1'b1;
            end
            OP_CLAIM: r_ins  <= 1'b1;
            OP_HIT:   r_hit  <= 1'b1;
            OP_FULL:  r_full <= 1'b1;
            OP_BIND: begin
                r_sw <= !r_bound_valid || (r_bound_slot != r_idx);
                r_mu <= (ms_old != r_ms);
                r_uu <= (us_old != r_us);
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    r_m_data <= {3'b000, r_uu, r_mu, r_sw, r_full, r_ins, r_hit,
                                 (r_hit || r_ins) ? r_idx : SLOT_W'(0)};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/hashed_state_cache_lookup_top.sv]
// Each item runs to completion before the next is accepted: a lookup or bind hashes
// the key, then probes slots in a linear scan from the home slot; invalidate and
// reset table skip the hash. The eight-step byte-serial hash and the one-read-per-probe
// slot memory bound the item rate, and any wait on the result side holds it further.
// Reset: synchronous, active low; clears slot valid bits, bound slot and output valid,
// not slot keys or serials.
`default_nettype none

module hashed_state_cache_lookup_top
    import hscl_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Item input
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [63:0] key, [95:64] matrix_serial, [127:96] uniform_serial
    input  wire logic [127:0]  i_s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]    i_s_axis_tuser,
    // Result output
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // [6:0] slot_index, [7] hit, [8] inserted, [9] table_full,
    // [10] need_switch, [11] need_matrix_upload, [12] need_uniform_upload,
    // [15:13] zero
    output logic [15:0]        o_m_axis_tdata
);

    // The sequencer steps through the control store; each microword picks
    // one datapath operation and an optional conditional jump on status.
    t_op   op;
    t_stat stat;

    hscl_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (op)
    );

    // Datapath: hash register, probe index, slot store, bind bookkeeping
    // and the output register. It accepts a transfer only in the idle step.
    hscl_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_stat          (stat),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
